[sv/pitp_pkg.sv]
// Package for the prefixed integer text parser.
// Holds widths, character constants, phase and radix codes, and the digit decoder.
// No dependencies.
`default_nettype none

package pitp_pkg;

	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 16;
	localparam int CHAR_BITS  = 8;

	localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_BITS-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_BITS-1:0] CH_UF    = 8'h46;
	localparam logic [3:0]           HEX_TEN  = 4'd10;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [CHAR_BITS-1:0]  char_t;

	// One-hot parse phase.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_ZERO   = 4'b0100,
		PH_DIGITS = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2
	} radix_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	// Decodes one character as a digit of the given radix. Decimal digits are
	// valid in every radix; letters a-f in either case only in hex.
	function automatic digit_t decode_digit(input char_t c, input radix_t rx);
		digit_t d;
		d.ok  = 1'b0;
		d.val = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d.ok  = 1'b1;
			d.val = 4'(c - CH_ZERO);
		end else if (rx == RX_HEX && c >= CH_LA && c <= CH_LF) begin
			d.ok  = 1'b1;
			d.val = 4'(c - CH_LA) + HEX_TEN;
		end else if (rx == RX_HEX && c >= CH_UA && c <= CH_UF) begin
			d.ok  = 1'b1;
			d.val = 4'(c - CH_UA) + HEX_TEN;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

[sv/prefixed_integer_text_parser_core.sv]
// Prefixed integer text parser, top level.
// A string's result is registered and loads once the result register is free.
// Throughput: one character per cycle; an ending character waits out a stalled result.
// Accumulate: shift-add by 8, 10 or 16, one short stage from input to result register.
// Reset: arst_n clears the input and result valid flags and returns the parse to idle.
// Depends on pitp_pkg.
`default_nettype none

module prefixed_integer_text_parser_core
	import pitp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [CHAR_BITS-1:0]  char_code,
	input  wire logic                  first_char,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [VALUE_BITS-1:0] value,
	output logic [COUNT_BITS-1:0]      consumed_count
);

	// Input register: one character beat waiting to be parsed.
	logic  valid_s1;
	char_t char_s1;
	logic  first_s1;

	// Parse state.
	phase_t phase_q;
	radix_t radix_q;
	value_t acc_q;
	logic   neg_q;
	count_t cnt_q;

	// Result register.
	logic   out_valid_q;
	value_t out_value_q;
	count_t out_count_q;

	// Next-state values computed from the held character.
	phase_t phase_d;
	radix_t radix_d;
	value_t acc_d;
	logic   neg_d;
	count_t cnt_d;
	logic   emit;
	value_t result_value;

	logic out_free;
	logic go_s1;
	logic in_fire;

	// The result register can load when it is empty or is being drained this cycle.
	assign out_free = !out_valid_q || !out_stall;
	// A character that ends no parse never needs the result register, so it
	// moves on even while a finished result waits to be taken.
	assign go_s1    = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !go_s1;
	assign in_fire  = in_valid && !in_stall;

	always_comb begin
		phase_t p;
		digit_t d;
		value_t mul;
		logic   done;

		phase_d = phase_q;
		radix_d = radix_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		cnt_d   = cnt_q;
		emit    = 1'b0;
		done    = 1'b0;
		p       = phase_q;
		mul     = '0;

		// A first-character flag restarts the parse from a clean state,
		// dropping any unfinished string.
		if (first_s1) begin
			radix_d = RX_DEC;
			acc_d   = '0;
			neg_d   = 1'b0;
			cnt_d   = '0;
			if (char_s1 == CH_MINUS) begin
				neg_d   = 1'b1;
				cnt_d   = count_t'(1);
				phase_d = PH_SIGN;
				done    = 1'b1;
			end else begin
				p = PH_SIGN;
			end
		end else if (phase_q == PH_IDLE) begin
			// Characters outside a string are dropped.
			done = 1'b1;
		end

		if (!done) begin
			if (p == PH_SIGN) begin
				if (char_s1 == CH_ZERO) begin
					radix_d = RX_OCT;
					cnt_d   = (cnt_d == CNT_MAX) ? cnt_d : cnt_d + count_t'(1);
					phase_d = PH_ZERO;
					done    = 1'b1;
				end
			end else if (p == PH_ZERO) begin
				if (char_s1 == CH_X) begin
					radix_d = RX_HEX;
					cnt_d   = (cnt_d == CNT_MAX) ? cnt_d : cnt_d + count_t'(1);
					phase_d = PH_DIGITS;
					done    = 1'b1;
				end
			end
		end

		// Digit phase; radix_d already holds the radix in force.
		d = decode_digit(char_s1, radix_d);
		if (!done) begin
			if (char_s1 != CH_NUL && d.ok) begin
				unique case (radix_d)
					RX_HEX:  mul = acc_d << 4;
					RX_OCT:  mul = acc_d << 3;
					default: mul = (acc_d << 3) + (acc_d << 1);
				endcase
				acc_d   = mul + value_t'(d.val);
				cnt_d   = (cnt_d == CNT_MAX) ? cnt_d : cnt_d + count_t'(1);
				phase_d = PH_DIGITS;
			end else begin
				emit    = 1'b1;
				phase_d = PH_IDLE;
			end
		end

		result_value = neg_d ? (value_t'(0) - acc_d) : acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1  <= char_code;
			first_s1 <= first_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			radix_q <= RX_DEC;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (go_s1) begin
			phase_q <= phase_d;
			radix_q <= radix_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			out_value_q <= result_value;
			out_count_q <= cnt_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = $signed(out_value_q);
	assign consumed_count = out_count_q;

endmodule

`default_nettype wire

[sv/pitp_checker.sv]
// Port-level checks for the prefixed integer text parser.
// Depends on pitp_pkg; bound to prefixed_integer_text_parser_core.
`default_nettype none

module pitp_checker
	import pitp_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    out_valid,
	input wire logic                    out_stall,
	input wire logic signed [VALUE_BITS-1:0] value,
	input wire logic [COUNT_BITS-1:0]   consumed_count
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(value) && $stable(consumed_count))
		else $error("result payload changed while stalled");

	// Nothing consumed means nothing accumulated.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && consumed_count == '0 |-> value == '0)
		else $error("empty parse gave a nonzero value");

	// One consumed character is a lone sign, a lone octal prefix or one decimal digit.
	a_single_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && consumed_count == COUNT_BITS'(1) |->
			value >= 0 && value <= 9)
		else $error("single-character parse out of range");

endmodule

bind prefixed_integer_text_parser_core pitp_checker u_pitp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.value          (value),
	.consumed_count (consumed_count)
);

`default_nettype wire

[sim/prefixed_integer_text_parser_checker.sv]
// Checker for the prefixed integer text parser: watches both channels, predicts each result.
// Depends on pitp_pkg; hands its mismatch count and the number of results still due to the bench.

module prefixed_integer_text_parser_checker
	import pitp_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic                    in_stall,
	input  wire logic [CHAR_BITS-1:0]    char_code,
	input  wire logic                    first_char,
	input  wire logic                    out_valid,
	input  wire logic                    out_stall,
	input  wire logic [VALUE_BITS-1:0]   value,
	input  wire logic [COUNT_BITS-1:0]   consumed_count,
	output int unsigned                  fail_count,
	output int unsigned                  numbers_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam char_t CH_CAP_Z = "Z";
	localparam char_t CASE_GAP = 8'd32;

	typedef struct {
		value_t number;
		count_t chars;
	} parse_result_t;

	parse_result_t awaited_numbers[$];
	int unsigned   mismatches;

	// Shadow copy of the parser state.
	phase_t sh_phase;
	radix_t sh_radix;
	value_t sh_acc;
	logic   sh_neg;
	count_t sh_tally;

	// Weight of a character as a digit in the given radix, -1 when it is no digit.
	function automatic int digit_weight(input char_t c, input radix_t rx);
		char_t folded;
		folded = (c >= CH_UA && c <= CH_CAP_Z) ? c + CASE_GAP : c;
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (rx == RX_HEX && folded >= CH_LA && folded <= CH_LF)
			return int'(folded - CH_LA) + int'(HEX_TEN);
		return -1;
	endfunction

	task automatic bump_tally();
		if (sh_tally != CNT_MAX)
			sh_tally = sh_tally + 1'b1;
	endtask

	// Advances the shadow parse by one character; done is set when it yields a number.
	task automatic advance_parse(input char_t c, input logic lead, output logic done,
			output value_t number, output count_t chars);
		int     w;
		value_t base;
		done   = 1'b0;
		number = '0;
		chars  = '0;
		if (lead) begin
			sh_radix = RX_DEC;
			sh_acc   = '0;
			sh_neg   = 1'b0;
			sh_tally = '0;
			sh_phase = PH_SIGN;
			if (c == CH_MINUS) begin
				sh_neg = 1'b1;
				bump_tally();
				return;
			end
		end else if (sh_phase == PH_IDLE) begin
			return;
		end

		if (sh_phase == PH_SIGN) begin
			if (c == CH_ZERO) begin
				sh_radix = RX_OCT;
				sh_phase = PH_ZERO;
				bump_tally();
				return;
			end
			sh_phase = PH_DIGITS;
		end else if (sh_phase == PH_ZERO) begin
			sh_phase = PH_DIGITS;
			if (c == CH_X) begin
				sh_radix = RX_HEX;
				bump_tally();
				return;
			end
		end

		w = (c == CH_NUL) ? -1 : digit_weight(c, sh_radix);
		if (w >= 0) begin
			base   = (sh_radix == RX_HEX) ? value_t'(16) :
			         (sh_radix == RX_OCT) ? value_t'(8) : value_t'(10);
			sh_acc = sh_acc * base + value_t'(w);
			bump_tally();
			return;
		end

		done     = 1'b1;
		number   = sh_neg ? value_t'(-sh_acc) : sh_acc;
		chars    = sh_tally;
		sh_phase = PH_IDLE;
	endtask

	always @(posedge clk or negedge arst_n) begin
		parse_result_t head;
		logic          done;
		value_t        number;
		count_t        chars;
		if (!arst_n) begin
			sh_phase   = PH_IDLE;
			sh_radix   = RX_DEC;
			sh_acc     = '0;
			sh_neg     = 1'b0;
			sh_tally   = '0;
			mismatches = 0;
			awaited_numbers.delete();
			fail_count  <= 0;
			numbers_due <= 0;
		end else begin
			// The result side goes first: a result never belongs to a beat taken at this edge.
			if (out_valid && !out_stall) begin
				if (awaited_numbers.size() == 0) begin
					$display("%0t: unexpected result beat: value %0d, count %0d", $time,
						$signed(value), consumed_count);
					mismatches++;
				end else begin
					head = awaited_numbers.pop_front();
					if (value !== head.number) begin
						$display("%0t: value mismatch: expected %0d, got %0d", $time,
							$signed(head.number), $signed(value));
						mismatches++;
					end
					if (consumed_count !== head.chars) begin
						$display("%0t: count mismatch: expected %0d, got %0d", $time,
							head.chars, consumed_count);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				advance_parse(char_code, first_char, done, number, chars);
				if (done)
					awaited_numbers.push_back('{number: number, chars: chars});
			end
			fail_count  <= mismatches;
			numbers_due <= awaited_numbers.size();
		end
	end

endmodule

[sim/prefixed_integer_text_parser_core_tb.sv]
// Testbench top for prefixed_integer_text_parser_core: drives character beats and result stalls.
// Depends on pitp_pkg, the core and prefixed_integer_text_parser_checker, which does the checking.

module prefixed_integer_text_parser_core_tb;
	import pitp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any accepted beat before the run is declared hung. The slowest correct
	// gap is a sender gap plus a full receiver stall plus the pass through the result register.
	localparam int unsigned HANG_LIMIT   = 2000;
	localparam int unsigned RANDOM_CHARS = 850;
	localparam int unsigned MAX_WAIT     = 10;

	localparam char_t CH_CAP_X = "X";

	// Every input is known from time zero.
	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           in_valid   = 1'b0;
	logic [CHAR_BITS-1:0]           char_code  = '0;
	logic                           first_char = 1'b0;
	logic                           out_stall  = 1'b0;
	logic                           in_stall;
	logic                           out_valid;
	logic signed [VALUE_BITS-1:0]   value;
	logic [COUNT_BITS-1:0]          consumed_count;

	int unsigned fail_count;
	int unsigned numbers_due;
	int unsigned hang_cycles = 0;
	// While calm is set both sides stop idling, which gives back-to-back stretches.
	logic        calm = 1'b0;
	logic        lead;
	int unsigned chars_counted = 0;

	prefixed_integer_text_parser_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.first_char     (first_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value),
		.consumed_count (consumed_count)
	);

	prefixed_integer_text_parser_checker parse_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.first_char     (first_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value),
		.consumed_count (consumed_count),
		.fail_count     (fail_count),
		.numbers_due    (numbers_due)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Reset is asserted from time zero and released on a clock edge, once for the whole run.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sends one character beat. The task is entered just after the clock rises and returns as
	// soon as the beat is accepted, with in_valid still high, so that a following beat
	// without a gap keeps valid asserted instead of dropping and raising it at once.
	task automatic send_char(input char_t c, input logic lead_flag);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		char_code  <= c;
		first_char <= lead_flag;
		do @(posedge clk); while (in_stall);
		chars_counted++;
	endtask

	// Sends the next character of the current string; the first one carries the start flag.
	task automatic put(input char_t c);
		send_char(c, lead);
		lead = 1'b0;
	endtask

	// Sends a whole string, optionally closed by the given terminator. An empty string
	// with a terminator is just the terminator with the start flag set.
	task automatic send_word(input string s, input logic closed, input char_t term);
		lead = 1'b1;
		for (int i = 0; i < s.len(); i++)
			put(char_t'(s[i]));
		if (closed)
			put(term);
	endtask

	// Draws a digit character that is valid in the chosen prefix: decimal digits for
	// decimal and octal (8 and 9 are taken in octal too), both letter cases for hex.
	function automatic char_t pick_digit(input radix_t rx);
		int unsigned k;
		k = (rx == RX_HEX) ? $urandom_range(0, 21) : $urandom_range(0, 9);
		if (k < 10)
			return CH_ZERO + char_t'(k);
		if (k < 16)
			return CH_LA + char_t'(k - 10);
		return CH_UA + char_t'(k - 16);
	endfunction

	// Stimulus.
	initial begin
		logic        neg;
		radix_t      rx;
		int unsigned ndig;
		wait (arst_n);
		@(posedge clk);

		// Directed strings: a signed decimal, a hex number with both letter cases ended by
		// an invalid letter, octal that takes 8 and 9, a bare prefix, an empty string, a
		// character while idle, a parse dropped by a restart, and the top character code.
		send_word("-9", 1'b1, CH_NUL);
		send_word("0x7fFa", 1'b1, "g");
		send_word("089", 1'b1, CH_NUL);
		send_word("-0x", 1'b1, CH_NUL);
		send_word("", 1'b1, CH_NUL);
		send_char(CH_NINE, 1'b0);
		send_word("12", 1'b0, CH_NUL);
		send_word("-0", 1'b1, 8'hff);
		send_word("0X", 1'b1, CH_NUL);

		// Random part: mostly well-formed strings with random content, some noise beats with
		// random codes and start flags, some strings cut short by the next start, and some
		// trailing characters after a terminator that the parser has to ignore.
		while (chars_counted < RANDOM_CHARS) begin
			if ($urandom_range(0, 15) == 0)
				calm = ~calm;
			if ($urandom_range(0, 9) == 0) begin
				send_char(char_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end else begin
				lead = 1'b1;
				neg  = $urandom_range(0, 2) == 0;
				rx   = radix_t'($urandom_range(0, 2));
				ndig = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
				if (neg)
					put(CH_MINUS);
				if (rx != RX_DEC)
					put(CH_ZERO);
				if (rx == RX_HEX)
					put(($urandom_range(0, 9) == 0) ? CH_CAP_X : CH_X);
				repeat (ndig) put(pick_digit(rx));
				if ($urandom_range(0, 7) != 0) begin
					put(($urandom_range(0, 1) == 0) ? CH_NUL : char_t'($urandom_range(0, 255)));
					repeat ($urandom_range(0, 2))
						send_char(char_t'($urandom_range(0, 255)), 1'b0);
				end
			end
		end
		lead = 1'b1;
		put(CH_NUL);

		// Drain: the checker's count of results due is registered, so let it update before
		// looking at it, then give the result register a little margin.
		in_valid <= 1'b0;
		@(posedge clk);
		while (numbers_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0 && numbers_due == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Result side: before each beat it stalls for a random number of cycles, then waits with
	// stall low until a result is taken.
	initial begin
		int unsigned hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Watchdog: ends the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				hang_cycles <= 0;
			end else if (hang_cycles >= HANG_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end else begin
				hang_cycles <= hang_cycles + 1;
			end
		end
	end

endmodule

[files.f]
sv/pitp_pkg.sv
sv/prefixed_integer_text_parser_core.sv
sv/pitp_checker.sv
sim/prefixed_integer_text_parser_checker.sv
sim/prefixed_integer_text_parser_core_tb.sv
